### rtl/y86if_pkg.sv
// ----------------------------------------------------------------------------
// y86if_pkg
// Shared types, codes and decode helpers of the Y86-64 fetch block.
// ----------------------------------------------------------------------------
package y86if_pkg;

  localparam int unsigned MemBytesDef = 4096;
  localparam int unsigned StoreAddrW  = 12;

  localparam logic [3:0] RegNone   = 4'hF;

  localparam logic [3:0] IcHalt    = 4'h0;
  localparam logic [3:0] IcNop     = 4'h1;
  localparam logic [3:0] IcRrmovq  = 4'h2;
  localparam logic [3:0] IcIrmovq  = 4'h3;
  localparam logic [3:0] IcRmmovq  = 4'h4;
  localparam logic [3:0] IcMrmovq  = 4'h5;
  localparam logic [3:0] IcOpq     = 4'h6;
  localparam logic [3:0] IcJxx     = 4'h7;
  localparam logic [3:0] IcCall    = 4'h8;
  localparam logic [3:0] IcPushq   = 4'hA;
  localparam logic [3:0] IcPopq    = 4'hB;

  localparam logic OpStore = 1'b0;
  localparam logic OpFetch = 1'b1;

  typedef enum logic [1:0] {
    ST_AOK = 2'd0,
    ST_HLT = 2'd1,
    ST_ADR = 2'd2,
    ST_INS = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [3:0]  icode;
    logic [3:0]  ifun;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [63:0] const_value;
    logic [63:0] next_seq_pc;
  } fetch_res_t;

  function automatic logic needs_regs(input logic [3:0] ic);
    logic r;
    unique case (ic) inside
      IcRrmovq, IcIrmovq, IcRmmovq, IcMrmovq, IcOpq, IcPushq, IcPopq: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic needs_const(input logic [3:0] ic);
    logic c;
    unique case (ic) inside
      IcIrmovq, IcRmmovq, IcMrmovq, IcJxx, IcCall: c = 1'b1;
      default: c = 1'b0;
    endcase
    return c;
  endfunction

endpackage

### rtl/y86if_mem.sv
// ----------------------------------------------------------------------------
// y86if_mem
// Byte-wide program memory with registered read and a clearing pass at reset.
// ----------------------------------------------------------------------------
module y86if_mem #(
  parameter int unsigned MEM_BYTES = y86if_pkg::MemBytesDef,
  localparam int unsigned AW = $clog2(MEM_BYTES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o,
  output logic          busy_o
);

  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] clr_q;
  logic          busy_q;
  logic [7:0]    rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (clr_q == AW'(MEM_BYTES - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 8'h00;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

### rtl/y86if_fetch.sv
// ----------------------------------------------------------------------------
// y86if_fetch
// Fetch sequencer: reads one instruction byte per cycle and assembles fields.
// ----------------------------------------------------------------------------
module y86if_fetch #(
  parameter int unsigned MEM_BYTES = y86if_pkg::MemBytesDef,
  localparam int unsigned AW  = $clog2(MEM_BYTES),
  localparam int unsigned AW1 = $clog2(MEM_BYTES + 1),
  localparam int unsigned SW  = y86if_pkg::StoreAddrW,
  localparam int unsigned XW  = (AW1 > SW) ? AW1 : SW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [SW-1:0]          store_address_i,
  input  logic [7:0]             store_byte_i,
  input  logic                   mem_busy_i,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output logic [7:0]             mem_wdata_o,
  output logic [AW-1:0]          mem_raddr_o,
  input  logic [7:0]             mem_rdata_i,
  output logic                   res_valid_o,
  input  logic                   res_take_i,
  output y86if_pkg::fetch_res_t  res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [63:0] pc_q, pc_d;
  logic [3:0]  idx_q, idx_d;
  logic        dv_q, dv_d;
  logic [3:0]  ic_q, ic_d, fn_q, fn_d, ra_q, ra_d, rb_q, rb_d, len_q, len_d;
  logic        regs_q, regs_d;
  logic [63:0] valc_q, valc_d;
  y86if_pkg::fetch_res_t res_q, res_d;

  logic          accept;
  logic [XW-1:0] st_addr;
  logic [3:0]    b;
  logic [3:0]    ic0;
  logic          regs0, cst0;
  logic [3:0]    len0;
  logic [AW1-1:0] rem;
  logic [63:0]   valc_n;
  logic [63:0]   valp;

  assign in_stall_o  = (state_q != S_IDLE) || mem_busy_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign st_addr     = XW'(store_address_i);
  assign mem_we_o    = accept && (operation_i == y86if_pkg::OpStore) &&
                       (st_addr < XW'(MEM_BYTES));
  assign mem_waddr_o = st_addr[AW-1:0];
  assign mem_wdata_o = store_byte_i;
  assign mem_raddr_o = pc_q[AW-1:0] + AW'(idx_q);

  assign b      = idx_q - 4'd1;
  assign ic0    = mem_rdata_i[7:4];
  assign regs0  = y86if_pkg::needs_regs(ic0);
  assign cst0   = y86if_pkg::needs_const(ic0);
  assign len0   = 4'd1 + (regs0 ? 4'd1 : 4'd0) + (cst0 ? 4'd8 : 4'd0);
  assign rem    = AW1'(MEM_BYTES) - pc_q[AW1-1:0];
  assign valc_n = {mem_rdata_i, valc_q[63:8]};
  assign valp   = pc_q + 64'(len_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    idx_d   = idx_q;
    dv_d    = dv_q;
    ic_d    = ic_q;
    fn_d    = fn_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    len_d   = len_q;
    regs_d  = regs_q;
    valc_d  = valc_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (operation_i == y86if_pkg::OpFetch)) begin
          ra_d   = y86if_pkg::RegNone;
          rb_d   = y86if_pkg::RegNone;
          valc_d = '0;
          idx_d  = 4'd0;
          dv_d   = 1'b0;
          if (pc_q >= 64'(MEM_BYTES)) begin
            res_d   = '{y86if_pkg::ST_ADR, y86if_pkg::IcNop, 4'h0, y86if_pkg::RegNone,
                        y86if_pkg::RegNone, 64'd0, 64'd0};
            pc_d    = pc_q + 64'd1;
            state_d = S_DONE;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        idx_d = idx_q + 4'd1;
        dv_d  = 1'b1;
        if (dv_q) begin
          if (b == 4'd0) begin
            ic_d   = ic0;
            fn_d   = mem_rdata_i[3:0];
            regs_d = regs0;
            len_d  = len0;
            if (ic0 > y86if_pkg::IcPopq) begin
              res_d   = '{y86if_pkg::ST_INS, ic0, 4'h0, y86if_pkg::RegNone,
                          y86if_pkg::RegNone, 64'd0, pc_q + 64'd1};
              pc_d    = pc_q + 64'd1;
              state_d = S_DONE;
            end else if (rem < AW1'(len0)) begin
              res_d   = '{y86if_pkg::ST_ADR, y86if_pkg::IcNop, 4'h0, y86if_pkg::RegNone,
                          y86if_pkg::RegNone, 64'd0, 64'd0};
              pc_d    = pc_q + 64'd1;
              state_d = S_DONE;
            end else if (len0 == 4'd1) begin
              res_d   = '{(ic0 == y86if_pkg::IcHalt) ? y86if_pkg::ST_HLT : y86if_pkg::ST_AOK,
                          ic0, mem_rdata_i[3:0], y86if_pkg::RegNone,
                          y86if_pkg::RegNone, 64'd0, pc_q + 64'd1};
              pc_d    = pc_q + 64'd1;
              state_d = S_DONE;
            end
          end else begin
            if (regs_q && (b == 4'd1)) begin
              ra_d = mem_rdata_i[7:4];
              rb_d = mem_rdata_i[3:0];
            end else begin
              valc_d = valc_n;
            end
            if (b == len_q - 4'd1) begin
              res_d   = '{y86if_pkg::ST_AOK, ic_q, fn_q, ra_d, rb_d, valc_d, valp};
              pc_d    = ((ic_q == y86if_pkg::IcJxx) || (ic_q == y86if_pkg::IcCall)) ?
                        valc_d : valp;
              state_d = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      idx_q   <= '0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      idx_q   <= idx_d;
      dv_q    <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ic_q   <= ic_d;
    fn_q   <= fn_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    len_q  <= len_d;
    regs_q <= regs_d;
    valc_q <= valc_d;
    res_q  <= res_d;
  end

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

### rtl/y86_instruction_fetch.sv
// ----------------------------------------------------------------------------
// y86_instruction_fetch
// Fetch: a fetch reads its instruction bytes one byte per cycle, then its word passes
// through the result register and the output register; when the PC already lies
// beyond memory, no byte is read.
// Throughput: one fetch in flight; the next word is accepted once the result
// has been handed to the output register; stores go back to back.
// Reset: PC clears to 0 and memory is zeroed while the input stalls.
// ----------------------------------------------------------------------------
module y86_instruction_fetch #(
  parameter int unsigned MEM_BYTES = y86if_pkg::MemBytesDef,
  localparam int unsigned AW = $clog2(MEM_BYTES),
  localparam int unsigned SW = y86if_pkg::StoreAddrW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          in_operation_i,
  input  logic [SW-1:0] in_store_address_i,
  input  logic [7:0]    in_store_byte_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    out_status_o,
  output logic [3:0]    out_icode_o,
  output logic [3:0]    out_ifun_o,
  output logic [3:0]    out_reg_a_o,
  output logic [3:0]    out_reg_b_o,
  output logic [63:0]   out_const_value_o,
  output logic [63:0]   out_next_seq_pc_o
);

  logic          mem_we, mem_busy;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          res_valid, res_take;
  y86if_pkg::fetch_res_t res, out_q;
  logic          out_valid_q;

  y86if_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  y86if_fetch #(.MEM_BYTES(MEM_BYTES)) u_fetch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (in_operation_i),
    .store_address_i (in_store_address_i),
    .store_byte_i    (in_store_byte_i),
    .mem_busy_i      (mem_busy),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .res_valid_o     (res_valid),
    .res_take_i      (res_take),
    .res_o           (res)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_q.status;
  assign out_icode_o       = out_q.icode;
  assign out_ifun_o        = out_q.ifun;
  assign out_reg_a_o       = out_q.reg_a;
  assign out_reg_b_o       = out_q.reg_b;
  assign out_const_value_o = out_q.const_value;
  assign out_next_seq_pc_o = out_q.next_seq_pc;

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> in_stall_o)
    else $error("input accepted during memory clear");

  a_adr_is_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == y86if_pkg::ST_ADR)) |->
      ((out_icode_o == y86if_pkg::IcNop) && (out_next_seq_pc_o == 64'd0) &&
       (out_const_value_o == 64'd0)))
    else $error("address error word is not a NOP");

  a_ins_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == y86if_pkg::ST_INS)) |->
      (out_icode_o > y86if_pkg::IcPopq))
    else $error("invalid status with a valid icode");

  a_take_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_q)
    else $error("result handoff lost");

endmodule

### test/y86_instruction_fetch_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_instruction_fetch_test
// Self-checking bench for the Y86-64 fetch block. Store words build short
// programs at the predicted PC and fetch words decode them; an internal copy
// of the fetch logic predicts each decoded word, which is compared field by
// field. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module y86_instruction_fetch_test;

  localparam int unsigned MemBytes     = y86if_pkg::MemBytesDef;
  localparam int unsigned AddrW        = $clog2(MemBytes);
  localparam int unsigned StAddrW      = y86if_pkg::StoreAddrW;
  localparam int          PlanCopy     = 0;
  localparam int          CheckCopy    = 1;
  localparam int unsigned RandomWords  = 510;
  localparam int unsigned IdleLimit    = 20000;
  localparam int unsigned DrainCycles  = 30;
  localparam logic [3:0]  IcInvalidTop = 4'hF;

  typedef struct packed {
    logic               op;
    logic [StAddrW-1:0] addr;
    logic [7:0]         data;
  } fetch_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               in_operation_i = y86if_pkg::OpStore;
  logic [StAddrW-1:0] in_store_address_i = '0;
  logic [7:0]         in_store_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         out_status_o;
  logic [3:0]         out_icode_o;
  logic [3:0]         out_ifun_o;
  logic [3:0]         out_reg_a_o;
  logic [3:0]         out_reg_b_o;
  logic [63:0]        out_const_value_o;
  logic [63:0]        out_next_seq_pc_o;

  logic [7:0]  prog_image [2][MemBytes];
  logic [63:0] pc_track [2];

  fetch_req_t             pending_words [$];
  y86if_pkg::fetch_res_t  fetch_results_due [$];

  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned stores_seen = 0;
  int unsigned fetches_seen = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  logic [15:0] tick = '0;

  y86_instruction_fetch #(
    .MEM_BYTES(MemBytes)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_operation_i    (in_operation_i),
    .in_store_address_i(in_store_address_i),
    .in_store_byte_i   (in_store_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_status_o      (out_status_o),
    .out_icode_o       (out_icode_o),
    .out_ifun_o        (out_ifun_o),
    .out_reg_a_o       (out_reg_a_o),
    .out_reg_b_o       (out_reg_b_o),
    .out_const_value_o (out_const_value_o),
    .out_next_seq_pc_o (out_next_seq_pc_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    tick <= tick + 16'd1;
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tick[8:7] == 2'b00 || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void reset_image(input int copy);
    pc_track[copy] = '0;
    for (int i = 0; i < MemBytes; i++) prog_image[copy][i] = 8'h00;
  endfunction

  function automatic void instr_layout(input logic [3:0] ic, output logic regs,
                                       output logic cst);
    regs = ic inside {y86if_pkg::IcRrmovq, y86if_pkg::IcIrmovq, y86if_pkg::IcRmmovq,
                      y86if_pkg::IcMrmovq, y86if_pkg::IcOpq, y86if_pkg::IcPushq,
                      y86if_pkg::IcPopq};
    cst  = ic inside {y86if_pkg::IcIrmovq, y86if_pkg::IcRmmovq, y86if_pkg::IcMrmovq,
                      y86if_pkg::IcJxx, y86if_pkg::IcCall};
  endfunction

  // Apply one word to a copy of the fetch unit; returns 1 when it yields a result.
  function automatic logic step_fetch_unit(input int copy, input fetch_req_t w,
                                           output y86if_pkg::fetch_res_t res);
    logic [63:0] pc;
    logic [63:0] len;
    logic [63:0] a;
    logic [7:0]  b0;
    logic [7:0]  rbyte;
    logic        regs;
    logic        cst;
    int          k;
    res = '{y86if_pkg::ST_ADR, y86if_pkg::IcNop, 4'h0, y86if_pkg::RegNone,
            y86if_pkg::RegNone, 64'h0, 64'h0};
    if (w.op == y86if_pkg::OpStore) begin
      if (w.addr < MemBytes) prog_image[copy][w.addr] = w.data;
      return 1'b0;
    end
    pc = pc_track[copy];
    pc_track[copy] = pc + 64'd1;
    if (pc >= MemBytes) return 1'b1;
    b0 = prog_image[copy][pc[AddrW-1:0]];
    if (b0[7:4] > y86if_pkg::IcPopq) begin
      res = '{y86if_pkg::ST_INS, b0[7:4], 4'h0, y86if_pkg::RegNone,
              y86if_pkg::RegNone, 64'h0, pc + 64'd1};
      return 1'b1;
    end
    instr_layout(b0[7:4], regs, cst);
    len = 64'd1 + 64'(regs) + (cst ? 64'd8 : 64'd0);
    if (MemBytes - pc < len) return 1'b1;
    res.status = (b0[7:4] == y86if_pkg::IcHalt) ? y86if_pkg::ST_HLT : y86if_pkg::ST_AOK;
    res.icode  = b0[7:4];
    res.ifun   = b0[3:0];
    if (regs) begin
      a = pc + 64'd1;
      rbyte = prog_image[copy][a[AddrW-1:0]];
      res.reg_a = rbyte[7:4];
      res.reg_b = rbyte[3:0];
    end
    if (cst) begin
      for (k = 7; k >= 0; k--) begin
        a = pc + 64'd1 + 64'(regs) + 64'(k);
        res.const_value = {res.const_value[55:0], prog_image[copy][a[AddrW-1:0]]};
      end
    end
    res.next_seq_pc = pc + len;
    pc_track[copy] = (b0[7:4] == y86if_pkg::IcJxx || b0[7:4] == y86if_pkg::IcCall) ?
                     res.const_value : res.next_seq_pc;
    return 1'b1;
  endfunction

  task automatic queue_word(input fetch_req_t w);
    y86if_pkg::fetch_res_t scratch;
    pending_words.push_back(w);
    void'(step_fetch_unit(PlanCopy, w, scratch));
  endtask

  task automatic queue_store(input logic [StAddrW-1:0] addr, input logic [7:0] data);
    queue_word('{y86if_pkg::OpStore, addr, data});
  endtask

  task automatic queue_fetch();
    queue_word('{y86if_pkg::OpFetch, StAddrW'($urandom), 8'($urandom)});
  endtask

  // Write the first keep bytes of an instruction at the given address.
  task automatic place_instr(input logic [63:0] at, input logic [3:0] ic,
                             input logic [3:0] fn, input logic [7:0] regs_byte,
                             input logic [63:0] valc, input int unsigned keep);
    logic        regs;
    logic        cst;
    logic [79:0] bytes;
    logic [63:0] a;
    int unsigned count;
    instr_layout(ic, regs, cst);
    bytes = regs ? {valc, regs_byte, ic, fn} : {8'h00, valc, ic, fn};
    count = 1 + (regs ? 1 : 0) + (cst ? 8 : 0);
    for (int unsigned i = 0; i < count && i < keep; i++) begin
      a = at + 64'(i);
      if (a < MemBytes) queue_store(a[StAddrW-1:0], bytes[8*i +: 8]);
    end
  endtask

  function automatic logic [63:0] jump_target();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
    if (r == 1) return 64'h0;
    return 64'($urandom_range(0, MemBytes - 21));
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    fetch_req_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid_i <= 1'b1;
        in_operation_i <= w.op;
        in_store_address_i <= w.addr;
        in_store_byte_i <= w.data;
        send_gap <= draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left <= draw_gap();
    end
  end

  always @(posedge clk_i) begin
    y86if_pkg::fetch_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (fetch_results_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got icode %h pc %h", $time,
                   out_icode_o, out_next_seq_pc_o);
          mismatch_count++;
        end else begin
          want = fetch_results_due.pop_front();
          check_field("status", 64'(want.status), 64'(out_status_o));
          check_field("icode", 64'(want.icode), 64'(out_icode_o));
          check_field("ifun", 64'(want.ifun), 64'(out_ifun_o));
          check_field("reg_a", 64'(want.reg_a), 64'(out_reg_a_o));
          check_field("reg_b", 64'(want.reg_b), 64'(out_reg_b_o));
          check_field("const_value", want.const_value, out_const_value_o);
          check_field("next_seq_pc", want.next_seq_pc, out_next_seq_pc_o);
          status_seen[want.status]++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (step_fetch_unit(CheckCopy, '{in_operation_i, in_store_address_i,
                                         in_store_byte_i}, want)) begin
          fetch_results_due.push_back(want);
          fetches_seen++;
        end else begin
          stores_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, IdleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] pc;
    logic [3:0]  ic;
    int unsigned pick;
    logic        is_jump;
    reset_image(PlanCopy);
    reset_image(CheckCopy);

    // halt from cleared memory, address extremes, jump past the top and wrap
    queue_fetch();
    queue_store('1, 8'hFF);
    queue_store('0, 8'h00);
    place_instr(pc_track[PlanCopy], y86if_pkg::IcJxx, 4'hF, 8'h00,
                64'hFFFF_FFFF_FFFF_FFFF, 10);
    queue_fetch();
    queue_fetch();
    queue_fetch();
    place_instr(pc_track[PlanCopy], IcInvalidTop, 4'h5, 8'h00, 64'h0, 10);
    queue_fetch();
    place_instr(pc_track[PlanCopy], y86if_pkg::IcRrmovq, 4'h0, 8'hF0, 64'h0, 10);
    queue_fetch();

    while (pending_words.size() < RandomWords) begin
      pc = pc_track[PlanCopy];
      pick = $urandom_range(0, 99);
      ic = 4'($urandom_range(0, 15));
      is_jump = (ic == y86if_pkg::IcJxx || ic == y86if_pkg::IcCall);
      if (pc[63]) begin
        queue_fetch();
      end else if (pick < 8) begin
        queue_store(StAddrW'($urandom), 8'($urandom));
      end else if (MemBytes - pc < 20 || pick < 25) begin
        place_instr(pc, ($urandom_range(0, 1) != 0) ? y86if_pkg::IcJxx : y86if_pkg::IcCall,
                    4'($urandom), 8'($urandom), jump_target(), 10);
        queue_fetch();
      end else begin
        place_instr(pc, ic, 4'($urandom), 8'($urandom),
                    is_jump ? jump_target() : {$urandom, $urandom},
                    (pick < 40 && !is_jump) ? $urandom_range(1, 9) : 10);
        queue_fetch();
      end
    end

    // run off the end of memory
    while (pc_track[PlanCopy][63]) queue_fetch();
    place_instr(pc_track[PlanCopy], y86if_pkg::IcJxx, 4'h0, 8'h00,
                64'(MemBytes - $urandom_range(1, 10)), 10);
    queue_fetch();
    repeat (12) begin
      pc = pc_track[PlanCopy];
      if (pc < MemBytes) begin
        place_instr(pc, 4'($urandom), 4'($urandom), 8'($urandom),
                    64'(MemBytes - $urandom_range(1, 10)), 10);
      end
      queue_fetch();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i || fetch_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d store words and %0d fetch words.", stores_seen, fetches_seen);
    $display("Decoded words by status: ok %0d, halt %0d, address %0d, invalid %0d.",
             status_seen[y86if_pkg::ST_AOK], status_seen[y86if_pkg::ST_HLT],
             status_seen[y86if_pkg::ST_ADR], status_seen[y86if_pkg::ST_INS]);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
